[hdl/lla_pkg.sv]
// Package for the log line assembler: widths, byte codes, register indexes,
// state type and the control byte filter.
// No dependencies.
package lla_pkg;

	// Line geometry
	localparam int LINE_MAX    = 32;
	localparam int LEVEL_COUNT = 11;
	localparam int LEN_W       = $clog2(LINE_MAX);
	localparam int SEV_W       = 4;
	localparam int STORE_AW    = SEV_W + LEN_W;
	localparam int STORE_DEPTH = LEVEL_COUNT << LEN_W;

	// Field widths
	localparam int BYTE_W    = 8;
	localparam int SEC_W     = 40;
	localparam int NSEC_W    = 30;
	localparam int TID_W     = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [LEN_W-1:0] FULL_LEN = LEN_W'(LINE_MAX - 1);

	// Byte codes
	localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;
	localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
	localparam logic [BYTE_W-1:0] CH_LF  = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_VT  = 8'h0b;
	localparam logic [BYTE_W-1:0] CH_FF  = 8'h0c;
	localparam logic [BYTE_W-1:0] CH_CR  = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_ENQ = 8'h05;
	localparam logic [BYTE_W-1:0] CH_BEL = 8'h07;
	localparam logic [BYTE_W-1:0] CH_SO  = 8'h0e;
	localparam logic [BYTE_W-1:0] CH_SI  = 8'h0f;
	localparam logic [BYTE_W-1:0] CH_DC1 = 8'h11;
	localparam logic [BYTE_W-1:0] CH_ESC = 8'h1b;
	localparam logic [BYTE_W-1:0] CH_DEL = 8'h7f;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ENABLED = 2'd0,
		REG_SINK_A  = 2'd1,
		REG_SINK_B  = 2'd2
	} cfg_reg_t;

	// Line start record
	typedef struct packed {
		logic [SEC_W-1:0]  sec;
		logic [NSEC_W-1:0] nsec;
		logic [TID_W-1:0]  tid;
	} meta_t;

	typedef enum logic {
		ST_IDLE,
		ST_STREAM
	} state_t;

	// Control bytes that are dropped without effect
	function automatic logic is_ignored(input logic [BYTE_W-1:0] b);
		logic hit;
		hit = (b == CH_NUL) || (b == CH_DEL) || (b == CH_SO) || (b == CH_SI) ||
			((b >= CH_ENQ) && (b <= CH_BEL)) || ((b >= CH_DC1) && (b <= CH_ESC));
		return hit;
	endfunction

endpackage

[hdl/lla_if.sv]
// Channel interfaces of the log line assembler: input byte, output line
// word and configuration write. Depends on lla_pkg.
interface lla_in_if;
	logic                        valid;
	logic                        ready;
	logic [lla_pkg::SEV_W-1:0]   severity;
	logic [lla_pkg::BYTE_W-1:0]  text_byte;
	logic                        end_of_write;
	logic [lla_pkg::SEC_W-1:0]   now_seconds;
	logic [lla_pkg::NSEC_W-1:0]  now_nanoseconds;
	logic [lla_pkg::TID_W-1:0]   thread_id;

	modport source(output valid, severity, text_byte, end_of_write, now_seconds,
		now_nanoseconds, thread_id, input ready);
	modport sink(input valid, severity, text_byte, end_of_write, now_seconds,
		now_nanoseconds, thread_id, output ready);
endinterface

interface lla_out_if;
	logic                        valid;
	logic                        ready;
	logic [lla_pkg::SEV_W-1:0]   line_severity;
	logic [lla_pkg::BYTE_W-1:0]  line_byte;
	logic                        last_of_line;
	logic [lla_pkg::SEC_W-1:0]   start_seconds;
	logic [lla_pkg::NSEC_W-1:0]  start_nanoseconds;
	logic [lla_pkg::TID_W-1:0]   writer_thread;
	logic                        to_sink_a;
	logic                        to_sink_b;

	modport source(output valid, line_severity, line_byte, last_of_line, start_seconds,
		start_nanoseconds, writer_thread, to_sink_a, to_sink_b, input ready);
	modport sink(input valid, line_severity, line_byte, last_of_line, start_seconds,
		start_nanoseconds, writer_thread, to_sink_a, to_sink_b, output ready);
endinterface

interface lla_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [lla_pkg::CFG_IDX_W-1:0]       index;
	logic [lla_pkg::LEVEL_COUNT-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

[hdl/log_line_assembler.sv]
// Log line assembler top level. Depends on lla_pkg and lla_if.
// A byte that commits nothing leaves input ready. A commit of n stored bytes
// streams n+1 words from the line store read port, one per cycle while output
// is not stalled, and holds input until done; a flush then a commit streams both.
// The first word passes the fetch sequencer, read stage and output register.
// Reset clears line lengths, CR flags and output valid, and enables all levels.
module log_line_assembler (
	input  logic         clk,
	input  logic         arst_n,
	lla_in_if.sink       byte_in,
	lla_out_if.source    line_out,
	lla_cfg_if.sink      cfg
);

	// Configuration registers
	logic [lla_pkg::LEVEL_COUNT-1:0] enabled_q, sink_a_q, sink_b_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= '1;
			sink_a_q  <= '1;
			sink_b_q  <= '1;
		end else if (cfg.valid) begin
			case (cfg.index)
				lla_pkg::REG_ENABLED: enabled_q <= cfg.data;
				lla_pkg::REG_SINK_A:  sink_a_q  <= cfg.data;
				lla_pkg::REG_SINK_B:  sink_b_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// Per-level control state
	logic [lla_pkg::LEN_W-1:0] len_q [lla_pkg::LEVEL_COUNT];
	logic                      cr_q  [lla_pkg::LEVEL_COUNT];

	lla_pkg::state_t state_q, state_nxt;

	// Decode of the offered byte
	logic [lla_pkg::SEV_W-1:0]  lvl;
	logic [lla_pkg::BYTE_W-1:0] b;
	logic                       acc, act, lvl_ok;
	logic                       is_lf, is_vt, is_ff, is_cr, is_bs, plain;
	logic [lla_pkg::LEN_W-1:0]  cur_len, base_len, len_nxt;
	logic                       cur_cr, crlf, flush, commit_b, sink_any;
	logic                       emit1, emit2, go_stream, cr_nxt, st_we_new, meta_we;
	lla_pkg::meta_t             now_meta;

	assign lvl = byte_in.severity;
	assign b   = byte_in.text_byte;
	assign acc = byte_in.valid && byte_in.ready;
	assign now_meta = '{sec: byte_in.now_seconds, nsec: byte_in.now_nanoseconds,
		tid: byte_in.thread_id};

	always_comb begin
		lvl_ok   = lvl < lla_pkg::SEV_W'(lla_pkg::LEVEL_COUNT);
		act      = acc && lvl_ok && enabled_q[lvl];
		is_lf    = b == lla_pkg::CH_LF;
		is_vt    = b == lla_pkg::CH_VT;
		is_ff    = b == lla_pkg::CH_FF;
		is_cr    = b == lla_pkg::CH_CR;
		is_bs    = b == lla_pkg::CH_BS;
		plain    = !(is_lf || is_vt || is_ff || is_cr || is_bs) && !lla_pkg::is_ignored(b);
		cur_len  = len_q[lvl];
		cur_cr   = cr_q[lvl];
		crlf     = cur_cr && is_lf;
		flush    = !cur_cr && (cur_len >= lla_pkg::FULL_LEN);
		base_len = (cur_cr || flush) ? '0 : cur_len;
		commit_b = !crlf && (is_lf || is_vt || is_ff);
		sink_any = sink_a_q[lvl] || sink_b_q[lvl];
		emit1    = (crlf || flush) && sink_any;
		emit2    = commit_b && sink_any;
		go_stream = emit1 || emit2;
		cr_nxt   = !crlf && is_cr && !byte_in.end_of_write;
		st_we_new = !crlf && plain;
		meta_we  = act && !crlf && (base_len == '0);

		// new line length after this byte
		if (crlf || commit_b) begin
			len_nxt = '0;
		end else if (is_cr) begin
			len_nxt = byte_in.end_of_write ? '0 : base_len;
		end else if (is_bs) begin
			len_nxt = (base_len == '0) ? '0 : base_len - 1'b1;
		end else if (plain) begin
			len_nxt = base_len + 1'b1;
		end else begin
			len_nxt = base_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lla_pkg::LEVEL_COUNT; i++) begin
				len_q[i] <= '0;
				cr_q[i]  <= 1'b0;
			end
		end else if (act) begin
			len_q[lvl] <= len_nxt;
			cr_q[lvl]  <= cr_nxt;
		end
	end

	// Item latched for a streaming commit
	logic [lla_pkg::SEV_W-1:0]  lvl_q;
	logic [lla_pkg::BYTE_W-1:0] byte_q;
	logic [lla_pkg::LEN_W-1:0]  base_q, cnt1_q, cnt2_q;
	lla_pkg::meta_t             new_meta_q;
	logic                       st_pend_q, has2_q, meta2_new_q;

	always_ff @(posedge clk) begin
		if (act && go_stream) begin
			lvl_q       <= lvl;
			byte_q      <= b;
			base_q      <= base_len;
			cnt1_q      <= cur_len;
			cnt2_q      <= base_len;
			new_meta_q  <= now_meta;
			st_pend_q   <= st_we_new;
			has2_q      <= emit2;
			meta2_new_q <= base_len == '0;
		end
	end

	// Fetch sequencer over the line store
	logic                      seg_q, fetch_done_q;
	logic [lla_pkg::LEN_W-1:0] fidx_q, cur_cnt;
	logic                      fetch, fetch_nl, advance, done;
	logic                      s1_vld_s1, s1_nl_s1, s1_seg_s1;
	logic                      ov_q;

	assign cur_cnt  = seg_q ? cnt2_q : cnt1_q;
	assign fetch    = (state_q == lla_pkg::ST_STREAM) && !fetch_done_q;
	assign fetch_nl = fidx_q == cur_cnt;
	assign advance  = !ov_q || line_out.ready;
	assign done     = fetch_done_q && !s1_vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q        <= 1'b0;
			fidx_q       <= '0;
			fetch_done_q <= 1'b1;
			s1_vld_s1    <= 1'b0;
		end else begin
			if (act && go_stream) begin
				seg_q        <= !emit1;
				fidx_q       <= '0;
				fetch_done_q <= 1'b0;
			end else if (fetch && advance) begin
				if (fetch_nl) begin
					if (!seg_q && has2_q) begin
						seg_q  <= 1'b1;
						fidx_q <= '0;
					end else begin
						fetch_done_q <= 1'b1;
					end
				end else begin
					fidx_q <= fidx_q + 1'b1;
				end
			end
			if (advance) begin
				s1_vld_s1 <= fetch;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			s1_nl_s1  <= fetch_nl;
			s1_seg_s1 <= seg_q;
		end
	end

	// Line store: one write port, one registered read port
	logic [lla_pkg::BYTE_W-1:0]   store_mem [lla_pkg::STORE_DEPTH];
	logic [lla_pkg::BYTE_W-1:0]   store_rd_s1;
	logic                         st_we;
	logic [lla_pkg::STORE_AW-1:0] st_waddr;
	logic [lla_pkg::BYTE_W-1:0]   st_wdata;

	always_comb begin
		if (state_q == lla_pkg::ST_STREAM) begin
			st_we    = done && st_pend_q;
			st_waddr = {lvl_q, base_q};
			st_wdata = byte_q;
		end else begin
			st_we    = act && !go_stream && st_we_new;
			st_waddr = {lvl, base_len};
			st_wdata = b;
		end
	end

	always_ff @(posedge clk) begin
		if (st_we) begin
			store_mem[st_waddr] <= st_wdata;
		end
		if (advance) begin
			store_rd_s1 <= store_mem[{lvl_q, fidx_q}];
		end
	end

	// Line start memory, read on accept (old value kept for the stream)
	lla_pkg::meta_t meta_mem [lla_pkg::LEVEL_COUNT];
	lla_pkg::meta_t meta_rd_s1;

	always_ff @(posedge clk) begin
		if (act) begin
			meta_rd_s1 <= meta_mem[lvl];
		end
		if (meta_we) begin
			meta_mem[lvl] <= now_meta;
		end
	end

	// Output register
	logic [lla_pkg::SEV_W-1:0]  o_sev_q;
	logic [lla_pkg::BYTE_W-1:0] o_byte_q;
	logic                       o_last_q, o_sa_q, o_sb_q;
	lla_pkg::meta_t             o_meta_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (advance) begin
			ov_q <= s1_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && s1_vld_s1) begin
			o_sev_q  <= lvl_q;
			o_byte_q <= s1_nl_s1 ? lla_pkg::CH_LF : store_rd_s1;
			o_last_q <= s1_nl_s1;
			o_meta_q <= (s1_seg_s1 && meta2_new_q) ? new_meta_q : meta_rd_s1;
			o_sa_q   <= sink_a_q[lvl_q];
			o_sb_q   <= sink_b_q[lvl_q];
		end
	end

	assign line_out.valid             = ov_q;
	assign line_out.line_severity     = o_sev_q;
	assign line_out.line_byte         = o_byte_q;
	assign line_out.last_of_line      = o_last_q;
	assign line_out.start_seconds     = o_meta_q.sec;
	assign line_out.start_nanoseconds = o_meta_q.nsec;
	assign line_out.writer_thread     = o_meta_q.tid;
	assign line_out.to_sink_a         = o_sa_q;
	assign line_out.to_sink_b         = o_sb_q;

	// State machine: next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			lla_pkg::ST_IDLE:   if (act && go_stream) state_nxt = lla_pkg::ST_STREAM;
			lla_pkg::ST_STREAM: if (done) state_nxt = lla_pkg::ST_IDLE;
			default:            state_nxt = lla_pkg::ST_IDLE;
		endcase
	end

	// State machine: outputs
	always_comb begin
		case (state_q)
			lla_pkg::ST_IDLE: byte_in.ready = 1'b1;
			default:          byte_in.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lla_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

`ifndef SYNTHESIS
	// fetch index never passes the newline slot of its segment
	a_fidx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fetch |-> (fidx_q <= cur_cnt))
		else $error("fetch index beyond line length");

	// the read stage only carries words while streaming
	a_s1_in_stream: assert property (@(posedge clk) disable iff (!arst_n)
		s1_vld_s1 |-> (state_q == lla_pkg::ST_STREAM))
		else $error("read stage valid outside stream");

	// a commit that emits blocks input on the next cycle
	a_block_input: assert property (@(posedge clk) disable iff (!arst_n)
		(act && go_stream) |=> !byte_in.ready)
		else $error("input not blocked during commit");

	// closing word of a line is a newline
	a_last_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && o_last_q) |-> (o_byte_q == lla_pkg::CH_LF))
		else $error("last word of line is not newline");
`endif

endmodule
